// File: rtl/core/lsbm_pkg.sv
// ----------------------------------------------------------------------------
// lsbm_pkg
// Shared types and constants for the load/store byte memory unit.
// ----------------------------------------------------------------------------
package lsbm_pkg;

  localparam int ACTION_W    = 3;
  localparam int BYTE_ADDR_W = 9;   // sum of two 8-bit operands
  localparam int DATA_W      = 32;
  localparam int LANES       = 4;   // byte lanes per word
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_WORD  = 3'd0,
    ACT_LOAD_BYTE  = 3'd1,
    ACT_LOAD_HALF  = 3'd2,
    ACT_LOAD_SBYTE = 3'd3,
    ACT_LOAD_SHALF = 3'd4,
    ACT_STORE_WORD = 3'd5,
    ACT_STORE_BYTE = 3'd6,
    ACT_STORE_HALF = 3'd7
  } action_t;

  // Encoding equals the index of the last byte of the access.
  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd3
  } size_t;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_t;

  typedef struct packed {
    logic                   is_store;
    logic                   is_signed;
    size_t                  size;
    logic [BYTE_ADDR_W-1:0] addr;
    logic [DATA_W-1:0]      data;
  } entry_t;

endpackage

// File: rtl/core/load_store_byte_memory_unit.sv
// ----------------------------------------------------------------------------
// load_store_byte_memory_unit
// Load/store unit over a byte-addressed little-endian data memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes action, base_value, offset_value
//   and store_data; the byte address is base_value + offset_value. Output
//   channel (out_valid/out_stall) returns one load_data per item, zero for
//   stores. Items complete in order.
//   Stages: front register, queue, access stage, result register.
//   Throughput: one item per cycle while the output is not stalled, set by
//   the four byte-lane banks, each with one read and one write port, so
//   any aligned or unaligned access of up to four bytes is one pass of the banks.
//   Reset: the memory is cleared one row of four bytes per cycle, over
//   ceil(MEMORY_BYTES / 4) rows (256 at the default size); in_stall stays
//   high until the pass is done.
//   Output stall: the result register holds, the access stage and a
//   two-entry queue fill, and in_stall rises once the front register has
//   no place to go.
// ----------------------------------------------------------------------------
module load_store_byte_memory_unit #(
  parameter int MEMORY_BYTES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lsbm_pkg::ACTION_W-1:0] action,
  input  logic [7:0]                    base_value,
  input  logic [7:0]                    offset_value,
  input  logic [lsbm_pkg::DATA_W-1:0]   store_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lsbm_pkg::DATA_W-1:0]   load_data
);
  import lsbm_pkg::*;

  logic   clearing;
  logic   q_full;
  logic   q_push;
  entry_t push_entry;
  logic   q_pop;
  logic   q_valid;
  entry_t head_entry;

  lsbm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .base_value   (base_value),
    .offset_value (offset_value),
    .store_data   (store_data),
    .clearing     (clearing),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  lsbm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  lsbm_back #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (head_entry),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .load_data (load_data)
  );

endmodule

// File: rtl/core/lsbm_front.sv
// ----------------------------------------------------------------------------
// lsbm_front
// Accepts items, forms the byte address and decodes the action.
// ----------------------------------------------------------------------------
module lsbm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lsbm_pkg::ACTION_W-1:0] action,
  input  logic [7:0]                    base_value,
  input  logic [7:0]                    offset_value,
  input  logic [lsbm_pkg::DATA_W-1:0]   store_data,
  input  logic                          clearing,
  input  logic                          q_full,
  output logic                          q_push,
  output lsbm_pkg::entry_t              q_entry
);
  import lsbm_pkg::*;

  logic   f_valid;
  entry_t f_entry;
  entry_t decoded;
  logic   accept;

  assign q_push   = f_valid && !q_full;
  assign in_stall = clearing || (f_valid && q_full);
  assign accept   = in_valid && !in_stall;
  assign q_entry  = f_entry;

  always_comb begin
    decoded.addr      = BYTE_ADDR_W'(base_value) + BYTE_ADDR_W'(offset_value);
    decoded.data      = store_data;
    decoded.is_store  = 1'b0;
    decoded.is_signed = 1'b0;
    decoded.size      = SIZE_WORD;
    case (action_t'(action))
      ACT_LOAD_WORD:  decoded.size = SIZE_WORD;
      ACT_LOAD_BYTE:  decoded.size = SIZE_BYTE;
      ACT_LOAD_HALF:  decoded.size = SIZE_HALF;
      ACT_LOAD_SBYTE: begin
        decoded.size      = SIZE_BYTE;
        decoded.is_signed = 1'b1;
      end
      ACT_LOAD_SHALF: begin
        decoded.size      = SIZE_HALF;
        decoded.is_signed = 1'b1;
      end
      ACT_STORE_WORD: begin
        decoded.size     = SIZE_WORD;
        decoded.is_store = 1'b1;
      end
      ACT_STORE_BYTE: begin
        decoded.size     = SIZE_BYTE;
        decoded.is_store = 1'b1;
      end
      ACT_STORE_HALF: begin
        decoded.size     = SIZE_HALF;
        decoded.is_store = 1'b1;
      end
      default: decoded.size = SIZE_WORD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_entry <= decoded;
    end
  end

endmodule

// File: rtl/core/lsbm_queue.sv
// ----------------------------------------------------------------------------
// lsbm_queue
// Short FIFO of decoded items between the front and the back.
// ----------------------------------------------------------------------------
module lsbm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lsbm_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output lsbm_pkg::entry_t head_entry
);
  import lsbm_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// File: rtl/core/lsbm_back.sv
// ----------------------------------------------------------------------------
// lsbm_back
// Four byte-lane memory banks, access stage and result register.
// ----------------------------------------------------------------------------
module lsbm_back #(
  parameter int MEMORY_BYTES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  lsbm_pkg::entry_t            q_entry,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lsbm_pkg::DATA_W-1:0] load_data
);
  import lsbm_pkg::*;

  localparam int ROWS  = (MEMORY_BYTES + LANES - 1) / LANES;
  localparam int ROW_W = $clog2(ROWS);

  state_t                  state;
  state_t                  state_next;
  logic [ROW_W-1:0]        clr_row;
  logic [LANES-1:0][7:0]   rd_lane;

  logic                    a_valid;
  logic                    a_is_store;
  logic                    a_signed;
  size_t                   a_size;
  logic [1:0]              a_lo;
  logic                    a_adv;
  logic [DATA_W-1:0]       raw;
  logic [DATA_W-1:0]       result;

  assign clearing = (state == ST_CLEAR);
  assign a_adv    = a_valid && (!out_valid || !out_stall);
  assign q_pop    = q_valid && !clearing && (!a_valid || a_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_row <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_row <= clr_row + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_row == ROW_W'(ROWS - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN:  state_next = ST_RUN;
      default: state_next = ST_CLEAR;
    endcase
  end

  // Byte k of an access lives in bank (addr + k) mod 4; banks below the
  // start lane take the next row.
  for (genvar i = 0; i < LANES; i++) begin : g_bank
    logic [7:0]       mem [ROWS];
    logic [1:0]       k;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] wr_row;
    logic             we;
    logic [7:0]       wd;
    logic [7:0]       rd_q;

    always_comb begin
      k      = 2'(i) - q_entry.addr[1:0];
      rd_row = ROW_W'(q_entry.addr[BYTE_ADDR_W-1:2])
             + ROW_W'(q_entry.addr[1:0] > 2'(i));
      if (clearing) begin
        we     = 1'b1;
        wr_row = clr_row;
        wd     = '0;
      end else begin
        we     = q_pop && q_entry.is_store && (k <= q_entry.size);
        wr_row = rd_row;
        wd     = 8'(q_entry.data >> {k, 3'b000});
      end
    end

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wr_row] <= wd;
      end
      if (q_pop) begin
        rd_q <= mem[rd_row];
      end
    end

    assign rd_lane[i] = rd_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (q_pop) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_is_store <= q_entry.is_store;
      a_signed   <= q_entry.is_signed;
      a_size     <= q_entry.size;
      a_lo       <= q_entry.addr[1:0];
    end
  end

  // Rotate lanes back into byte order, then trim and extend.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      raw[k*8 +: 8] = rd_lane[a_lo + 2'(k)];
    end
    case (a_size)
      SIZE_BYTE: result = {{24{a_signed & raw[7]}}, raw[7:0]};
      SIZE_HALF: result = {{16{a_signed & raw[15]}}, raw[15:0]};
      SIZE_WORD: result = raw;
      default:   result = raw;
    endcase
    if (a_is_store) begin
      result = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      load_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid && !a_valid)
    else $error("item in flight during memory clear");

  a_hold_access: assert property (@(posedge clk) disable iff (rst)
    a_valid && out_valid && out_stall |=> a_valid)
    else $error("access stage dropped an item under stall");

  a_store_zero: assert property (@(posedge clk) disable iff (rst)
    a_adv && a_is_store |=> out_valid && load_data == '0)
    else $error("store result not zero");
`endif

endmodule

// File: test/tb_load_store_byte_memory_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_load_store_byte_memory_unit
// Self-checking bench for the load/store byte memory unit.
// A short list of hand-picked accesses runs first, then random loads and
// stores. Most random addresses fall in a few hot windows so that loads read
// back what was stored. A byte-level memory image predicts every result that
// the table does not give. Both sides idle at random, and the receiver holds
// off once for a long stretch so that the unit backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_load_store_byte_memory_unit;
  import lsbm_pkg::*;

  localparam int MEMORY_BYTES  = 1024;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int SEGMENT_ITEMS = 150;
  localparam int MAX_WAIT      = 18;
  localparam int HOLD_CYCLES   = 80;
  localparam int PRESSURE_ITEM = 160;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int SMOKE_COUNT   = 25;

  typedef struct packed {
    action_t     act;
    logic [7:0]  base;
    logic [7:0]  offs;
    logic [31:0] data;
    logic        has_answer;
    logic [31:0] answer;
  } access_t;

  typedef struct packed {
    action_t     act;
    logic [8:0]  addr;
    logic [31:0] load_value;
  } result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  action;
  logic [7:0]  base_value;
  logic [7:0]  offset_value;
  logic [31:0] store_data;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] load_data;

  // answer typed into the table for the item on the input, if any
  logic        row_has_answer;
  logic [31:0] row_answer;

  logic [7:0]  mem_image [MEMORY_BYTES];
  result_t     predicted_results [$];
  access_t     smoke_rows [SMOKE_COUNT];

  bit          no_idle;
  bit          hold_req;
  bit          held_off;
  int          error_count;
  int          load_count;
  int          store_count;
  int          checked_count;
  int          idle_cycles = 0;

  load_store_byte_memory_unit #(
    .MEMORY_BYTES(MEMORY_BYTES)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .base_value  (base_value),
    .offset_value(offset_value),
    .store_data  (store_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .load_data   (load_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Read or update the memory image and return the load value.
  function automatic logic [31:0] predict_access(input action_t act, input logic [8:0] addr,
                                                 input logic [31:0] data);
    logic [31:0] word;
    int          nbytes;
    word = '0;
    for (int i = 0; i < 4; i++) word[8*i +: 8] = mem_image[(addr + i) % MEMORY_BYTES];
    case (act)
      ACT_LOAD_WORD:  return word;
      ACT_LOAD_BYTE:  return {24'h0, word[7:0]};
      ACT_LOAD_HALF:  return {16'h0, word[15:0]};
      ACT_LOAD_SBYTE: return {{24{word[7]}}, word[7:0]};
      ACT_LOAD_SHALF: return {{16{word[15]}}, word[15:0]};
      default: begin
        nbytes = (act == ACT_STORE_WORD) ? 4 : (act == ACT_STORE_BYTE) ? 1 : 2;
        for (int i = 0; i < nbytes; i++) mem_image[(addr + i) % MEMORY_BYTES] = data[8*i +: 8];
        return '0;
      end
    endcase
  endfunction

  function automatic int unsigned draw_wait();
    if (no_idle) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, MAX_WAIT);
    return $urandom_range(0, 3);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("MISMATCH %s: load_data %h, expected %h", what, got, want);
  endtask

  // Offer one item from the falling edge; return at the falling edge after acceptance.
  task automatic drive_item(input access_t item);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    action         = item.act;
    base_value     = item.base;
    offset_value   = item.offs;
    store_data     = item.data;
    row_has_answer = item.has_answer;
    row_answer     = item.answer;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Predict on input acceptance, check on output acceptance.
  always @(posedge clk) begin
    result_t r;
    if (!rst && in_valid && !in_stall) begin
      r.act        = action_t'(action);
      r.addr       = 9'(base_value) + 9'(offset_value);
      r.load_value = predict_access(r.act, r.addr, store_data);
      if (row_has_answer) r.load_value = row_answer;
      predicted_results.push_back(r);
      if (action >= ACT_STORE_WORD) store_count++;
      else load_count++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("result with no item pending", load_data, 'x);
      end else begin
        r = predicted_results.pop_front();
        checked_count++;
        if (load_data !== r.load_value)
          report_mismatch($sformatf("%s at %0d", r.act.name(), r.addr), load_data,
                          r.load_value);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles with no item moving", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall for a random wait before each result, or once for the long hold-off.
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        n        = HOLD_CYCLES;
        hold_req = 1'b0;
        held_off = 1'b1;
      end else begin
        n = draw_wait();
      end
      if (n != 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    access_t item;
    rst            = 1'b1;
    in_valid       = 1'b0;
    action         = ACT_LOAD_WORD;
    base_value     = '0;
    offset_value   = '0;
    store_data     = '0;
    row_has_answer = 1'b0;
    row_answer     = '0;
    no_idle        = 1'b0;
    hold_req       = 1'b0;
    held_off       = 1'b0;
    error_count    = 0;
    load_count     = 0;
    store_count    = 0;
    checked_count  = 0;
    for (int i = 0; i < MEMORY_BYTES; i++) mem_image[i] = 8'h00;

    smoke_rows = '{
      '{ACT_LOAD_WORD,  8'd0,   8'd0,   32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ACT_LOAD_WORD,  8'd255, 8'd255, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ACT_LOAD_SBYTE, 8'd255, 8'd255, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
      '{ACT_STORE_WORD, 8'd0,   8'd0,   32'h80FF_7F01, 1'b1, 32'h0000_0000},
      '{ACT_LOAD_WORD,  8'd0,   8'd0,   32'h0000_0000, 1'b1, 32'h80FF_7F01},
      '{ACT_LOAD_BYTE,  8'd0,   8'd0,   32'h0000_0000, 1'b1, 32'h0000_0001},
      '{ACT_LOAD_SBYTE, 8'd3,   8'd0,   32'h0000_0000, 1'b1, 32'hFFFF_FF80},
      '{ACT_LOAD_BYTE,  8'd0,   8'd3,   32'h0000_0000, 1'b0, 32'h0000_0000},
      '{ACT_LOAD_HALF,  8'd1,   8'd0,   32'h0000_0000, 1'b1, 32'h0000_FF7F},
      '{ACT_LOAD_SHALF, 8'd0,   8'd2,   32'h0000_0000, 1'b1, 32'hFFFF_80FF},
      '{ACT_LOAD_SHALF, 8'd0,   8'd0,   32'h0000_0000, 1'b1, 32'h0000_7F01},
      '{ACT_STORE_WORD, 8'd255, 8'd255, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
      '{ACT_LOAD_WORD,  8'd255, 8'd255, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
      '{ACT_STORE_HALF, 8'd128, 8'd129, 32'h1234_ABCD, 1'b1, 32'h0000_0000},
      '{ACT_LOAD_WORD,  8'd0,   8'd255, 32'h0000_0000, 1'b1, 32'hABCD_0000},
      '{ACT_STORE_BYTE, 8'd100, 8'd100, 32'hFFFF_FF7E, 1'b1, 32'h0000_0000},
      '{ACT_LOAD_HALF,  8'd200, 8'd0,   32'h0000_0000, 1'b0, 32'h0000_0000},
      '{ACT_LOAD_SBYTE, 8'd0,   8'd200, 32'h0000_0000, 1'b1, 32'h0000_007E},
      '{ACT_STORE_HALF, 8'd0,   8'd1,   32'h0000_8001, 1'b1, 32'h0000_0000},
      '{ACT_LOAD_WORD,  8'd0,   8'd0,   32'h0000_0000, 1'b1, 32'h8080_0101},
      '{ACT_LOAD_SHALF, 8'd1,   8'd1,   32'h0000_0000, 1'b1, 32'hFFFF_8080},
      '{ACT_STORE_WORD, 8'd1,   8'd2,   32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ACT_LOAD_WORD,  8'd0,   8'd0,   32'h0000_0000, 1'b1, 32'h0080_0101},
      '{ACT_LOAD_HALF,  8'd255, 8'd254, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{ACT_LOAD_SHALF, 8'd255, 8'd254, 32'h0000_0000, 1'b1, 32'hFFFF_FF00}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int k = 0; k < SMOKE_COUNT; k++) drive_item(smoke_rows[k]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // alternate segments with and without idling
      no_idle = ((n / SEGMENT_ITEMS) % 2) == 1;
      if (n == PRESSURE_ITEM) hold_req = 1'b1;

      if ($urandom_range(0, 9) < 4)
        item.act = action_t'($urandom_range(ACT_STORE_WORD, ACT_STORE_HALF));
      else
        item.act = action_t'($urandom_range(ACT_LOAD_WORD, ACT_LOAD_SHALF));

      // hot windows keep loads reading back recent stores
      case ($urandom_range(0, 3))
        0: begin
          item.base = 8'($urandom_range(0, 255));
          item.offs = 8'($urandom_range(0, 255));
        end
        1: begin
          item.base = 8'($urandom_range(240, 255));
          item.offs = 8'($urandom_range(240, 255));
        end
        2: begin
          item.base = 8'($urandom_range(0, 7));
          item.offs = 8'($urandom_range(0, 7));
        end
        default: begin
          item.base = 8'($urandom_range(100, 115));
          item.offs = 8'($urandom_range(20, 35));
        end
      endcase

      case ($urandom_range(0, 7))
        0:       item.data = 32'h0000_0000;
        1:       item.data = 32'hFFFF_FFFF;
        2:       item.data = 32'h8080_8080 | ($urandom & 32'h7F7F_7F7F);
        default: item.data = $urandom;
      endcase

      item.has_answer = 1'b0;
      item.answer     = '0;
      drive_item(item);
    end
    in_valid       = 1'b0;
    row_has_answer = 1'b0;

    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0)
      report_mismatch("results still pending at end", 'x, predicted_results[0].load_value);

    $display("Checked %0d results from %0d loads and %0d stores over all eight actions,",
             checked_count, load_count, store_count);
    $display("with random idling, no-idle bursts and a %0d-cycle output hold-off (%s).",
             HOLD_CYCLES, held_off ? "done" : "missed");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
